@@ src/qsi_pkg.sv @@
// package: shared types and constants of the quadric intersection block
`timescale 1ns / 1ps
package qsi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QW        = 64;   // magnitude width of the discriminant
    localparam int SW        = 32;   // square root width
    localparam int NW        = 33;   // numerator magnitude width
    localparam int DW        = 33;   // divisor width
    localparam int DNW       = NW + FRAC_BITS; // shifted dividend width
    localparam int QUOW      = DNW;  // quotient width before saturation
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW   = 2;

    typedef struct packed {
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
        logic               outside_sense;
    } qsi_in_t;

    typedef struct packed {
        logic        hits;
        logic [31:0] distance;
    } qsi_out_t;

    // divide selects which operand order the back end uses
    typedef enum logic [1:0] {
        OP_MISS     = 2'd0,
        OP_ZERO     = 2'd1,   // hit with distance clamped at zero
        OP_ROOT_A   = 2'd2,   // (S + |B|) / |A|
        OP_C_ROOT   = 2'd3    // |C| / (S + |B|)
    } qsi_op_t;

    // classified request passed from front to back
    typedef struct packed {
        qsi_op_t       op;      // provisional; miss on negative discriminant
        logic          neg_q;   // discriminant negative
        logic [QW-1:0] q_mag;
        logic [31:0]   b_mag;
        logic [31:0]   a_mag;
        logic [31:0]   c_mag;
    } qsi_cls_t;

endpackage

@@ src/quadratic_surface_intersect.sv @@
// top level: ray-quadric intersection distance with decoupled front and back
`timescale 1ns / 1ps
// Accepts one request per cycle while in_stall is low and returns one result
// per request, in order. A request passes 87 register stages: 2 front stages,
// 1 queue slot, 33 square root stages, 50 divider stages (operand setup plus 49
// quotient bits) and the output register. Throughput is one per cycle while no
// result is held by out_stall, set by the pipelined root and divider, which
// produce one bit per stage each. The back part freezes only while a finished
// result is held. The front part keeps going and fills the four-entry queue.
// Intake stops only when the queue is full and the front part holds a
// classified request.
module quadratic_surface_intersect (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  qsi_pkg::qsi_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output qsi_pkg::qsi_out_t out_data
);
    logic              adv;
    logic              f_adv;
    logic              f_valid;
    qsi_pkg::qsi_cls_t f_data;
    logic              q_empty;
    qsi_pkg::qsi_cls_t q_data;
    logic [qsi_pkg::FIFO_AW:0] q_count;
    logic              acc;
    logic              q_rd;

    // back pipeline moves unless a finished result is held
    assign adv = !(out_valid && out_stall);
    // front moves unless its last stage is blocked by a full queue
    assign f_adv    = !(f_valid &&
                        (q_count == (qsi_pkg::FIFO_AW+1)'(qsi_pkg::FIFO_DEPTH)));
    assign in_stall = !f_adv;
    assign acc      = in_valid && !in_stall;
    assign q_rd     = adv && !q_empty;

    qsi_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (acc),
        .in_data  (in_data),
        .adv      (f_adv),
        .out_valid(f_valid),
        .out_data (f_data)
    );

    qsi_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_valid && f_adv),
        .wr_data (f_data),
        .rd_en   (q_rd),
        .rd_data (q_data),
        .empty   (q_empty),
        .count   (q_count)
    );

    qsi_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_rd),
        .in_data  (q_data),
        .adv      (adv),
        .out_valid(out_valid),
        .out_data (out_data)
    );

    // a miss never carries a distance
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hits |-> out_data.distance == '0)
        else $error("miss with nonzero distance");
    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
    // no intake while the front is blocked by a full queue
    a_no_acc: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && (q_count == (qsi_pkg::FIFO_AW+1)'(qsi_pkg::FIFO_DEPTH)) |-> in_stall)
        else $error("request taken while queue full");

endmodule

@@ src/qsi_front.sv @@
// front end: products, discriminant and branch classification, two stages
`timescale 1ns / 1ps
module qsi_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  qsi_pkg::qsi_in_t    in_data,
    input  logic                adv,
    output logic                out_valid,
    output qsi_pkg::qsi_cls_t   out_data
);
    // stage 1 registers
    logic               v1_reg;
    logic signed [63:0] bb_reg;
    logic signed [63:0] ac_reg;
    qsi_pkg::qsi_op_t   op1_reg;
    logic [31:0]        a1_reg, b1_reg, c1_reg;
    // stage 2
    logic               v2_reg;
    qsi_pkg::qsi_cls_t  cls_reg;

    logic signed [32:0] a_s, b_s, c_s;
    logic [31:0]        a_mag, b_mag, c_mag;
    qsi_pkg::qsi_op_t   op_c;
    logic signed [64:0] q_s;

    always_comb
    begin
        a_s   = {in_data.coef_a[31], in_data.coef_a};
        b_s   = {in_data.coef_b[31], in_data.coef_b};
        c_s   = {in_data.coef_c[31], in_data.coef_c};
        a_mag = 32'(a_s < 0 ? -a_s : a_s);
        b_mag = 32'(b_s < 0 ? -b_s : b_s);
        c_mag = 32'(c_s < 0 ? -c_s : c_s);
        if (!in_data.outside_sense)
        begin
            if (b_s <= 0)
                op_c = (a_s > 0) ? qsi_pkg::OP_ROOT_A : qsi_pkg::OP_MISS;
            else
                op_c = (c_s < 0) ? qsi_pkg::OP_C_ROOT : qsi_pkg::OP_ZERO;
        end
        else
        begin
            if (b_s >= 0)
                op_c = (a_s < 0) ? qsi_pkg::OP_ROOT_A : qsi_pkg::OP_MISS;
            else
                op_c = (c_s > 0) ? qsi_pkg::OP_C_ROOT : qsi_pkg::OP_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign q_s = {bb_reg[63], bb_reg} - {ac_reg[63], ac_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bb_reg  <= 64'(b_s * b_s);
            ac_reg  <= 64'(a_s * c_s);
            op1_reg <= op_c;
            a1_reg  <= a_mag;
            b1_reg  <= b_mag;
            c1_reg  <= c_mag;
            cls_reg.op    <= op1_reg;
            cls_reg.neg_q <= q_s[64];
            cls_reg.q_mag <= q_s[63:0];
            cls_reg.a_mag <= a1_reg;
            cls_reg.b_mag <= b1_reg;
            cls_reg.c_mag <= c1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = cls_reg;

endmodule

@@ src/qsi_fifo.sv @@
// small request queue between front and back
`timescale 1ns / 1ps
module qsi_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  qsi_pkg::qsi_cls_t  wr_data,
    input  logic               rd_en,
    output qsi_pkg::qsi_cls_t  rd_data,
    output logic               empty,
    output logic [qsi_pkg::FIFO_AW:0] count
);
    qsi_pkg::qsi_cls_t mem [qsi_pkg::FIFO_DEPTH];
    logic [qsi_pkg::FIFO_AW-1:0] wp_reg, rp_reg;
    logic [qsi_pkg::FIFO_AW:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd_en) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (qsi_pkg::FIFO_AW+1)'(wr_en)
                               - (qsi_pkg::FIFO_AW+1)'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wp_reg] <= wr_data;
    end

    assign rd_data = mem[rp_reg];
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;

endmodule

@@ src/qsi_back.sv @@
// back end: pipelined square root and divider, saturation, output register
`timescale 1ns / 1ps
module qsi_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  qsi_pkg::qsi_cls_t  in_data,
    input  logic               adv,
    output logic               out_valid,
    output qsi_pkg::qsi_out_t  out_data
);
    localparam int SQ_ST = qsi_pkg::SW;      // one result bit per stage
    localparam int DV_ST = qsi_pkg::QUOW;    // one quotient bit per stage

    // square root pipeline: restoring, one bit a stage
    logic                  sv_reg  [SQ_ST+1];
    logic [qsi_pkg::QW+1:0] srem_reg[SQ_ST+1];
    logic [qsi_pkg::QW-1:0] sq_reg  [SQ_ST+1];
    logic [qsi_pkg::SW-1:0] sroot_reg[SQ_ST+1];
    qsi_pkg::qsi_cls_t      sc_reg  [SQ_ST+1];

    // divider pipeline
    logic                   dv_reg  [DV_ST+1];
    logic [qsi_pkg::DW:0]   drem_reg[DV_ST+1];
    logic [qsi_pkg::DNW-1:0] dnum_reg[DV_ST+1];
    logic [qsi_pkg::DW-1:0] dden_reg[DV_ST+1];
    logic [qsi_pkg::QUOW-1:0] dquo_reg[DV_ST+1];
    logic                   dhit_reg[DV_ST+1];
    logic                   dwork_reg[DV_ST+1];

    logic                   ov_reg;
    qsi_pkg::qsi_out_t      out_reg;

    // valid bits of the root, divider and output stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= SQ_ST; i++) sv_reg[i] <= 1'b0;
            for (int i = 0; i <= DV_ST; i++) dv_reg[i] <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            sv_reg[0] <= in_valid;
            for (int i = 1; i <= SQ_ST; i++) sv_reg[i] <= sv_reg[i-1];
            dv_reg[0] <= sv_reg[SQ_ST];
            for (int i = 1; i <= DV_ST; i++) dv_reg[i] <= dv_reg[i-1];
            ov_reg <= dv_reg[DV_ST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            srem_reg[0]  <= '0;
            sq_reg[0]    <= in_data.q_mag;
            sroot_reg[0] <= '0;
            sc_reg[0]    <= in_data;
            for (int i = 1; i <= SQ_ST; i++)
            begin
                logic [qsi_pkg::QW+1:0] r;
                logic [qsi_pkg::QW+1:0] t;
                r = {srem_reg[i-1][qsi_pkg::QW-1:0], sq_reg[i-1][qsi_pkg::QW-1 -: 2]};
                t = {(qsi_pkg::QW-qsi_pkg::SW)'(0), sroot_reg[i-1], 2'b01};
                if (r >= t)
                begin
                    srem_reg[i]  <= r - t;
                    sroot_reg[i] <= {sroot_reg[i-1][qsi_pkg::SW-2:0], 1'b1};
                end
                else
                begin
                    srem_reg[i]  <= r;
                    sroot_reg[i] <= {sroot_reg[i-1][qsi_pkg::SW-2:0], 1'b0};
                end
                sq_reg[i] <= {sq_reg[i-1][qsi_pkg::QW-3:0], 2'b00};
                sc_reg[i] <= sc_reg[i-1];
            end
        end
    end

    // divider operand setup from the root stage
    qsi_pkg::qsi_cls_t      c_end;
    logic [qsi_pkg::DW-1:0] s_plus_b;
    logic [qsi_pkg::NW-1:0] num_c;
    logic [qsi_pkg::DW-1:0] den_c;
    logic                   hit_c, work_c;

    always_comb
    begin
        c_end    = sc_reg[SQ_ST];
        s_plus_b = {1'b0, sroot_reg[SQ_ST]} + {1'b0, c_end.b_mag};
        hit_c    = 1'b0;
        work_c   = 1'b0;
        num_c    = '0;
        den_c    = {{(qsi_pkg::DW-1){1'b0}}, 1'b1};
        if (!c_end.neg_q)
        begin
            case (c_end.op)
                qsi_pkg::OP_ROOT_A:
                begin
                    hit_c = 1'b1; work_c = 1'b1;
                    num_c = s_plus_b;
                    den_c = {1'b0, c_end.a_mag};
                end
                qsi_pkg::OP_C_ROOT:
                begin
                    hit_c = 1'b1; work_c = 1'b1;
                    num_c = {1'b0, c_end.c_mag};
                    den_c = s_plus_b;
                end
                qsi_pkg::OP_ZERO: hit_c = 1'b1;
                default: hit_c = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            drem_reg[0]  <= '0;
            dnum_reg[0]  <= {num_c, {qsi_pkg::FRAC_BITS{1'b0}}};
            dden_reg[0]  <= den_c;
            dquo_reg[0]  <= '0;
            dhit_reg[0]  <= hit_c;
            dwork_reg[0] <= work_c;
            for (int i = 1; i <= DV_ST; i++)
            begin
                logic [qsi_pkg::DW:0] r;
                r = {drem_reg[i-1][qsi_pkg::DW-1:0], dnum_reg[i-1][qsi_pkg::DNW-1]};
                if (r >= {1'b0, dden_reg[i-1]})
                begin
                    drem_reg[i] <= r - {1'b0, dden_reg[i-1]};
                    dquo_reg[i] <= {dquo_reg[i-1][qsi_pkg::QUOW-2:0], 1'b1};
                end
                else
                begin
                    drem_reg[i] <= r;
                    dquo_reg[i] <= {dquo_reg[i-1][qsi_pkg::QUOW-2:0], 1'b0};
                end
                dnum_reg[i]  <= {dnum_reg[i-1][qsi_pkg::DNW-2:0], 1'b0};
                dden_reg[i]  <= dden_reg[i-1];
                dhit_reg[i]  <= dhit_reg[i-1];
                dwork_reg[i] <= dwork_reg[i-1];
            end
            out_reg.hits <= dhit_reg[DV_ST];
            if (!dwork_reg[DV_ST])
                out_reg.distance <= '0;
            else if (|dquo_reg[DV_ST][qsi_pkg::QUOW-1:32])
                out_reg.distance <= '1;
            else
                out_reg.distance <= dquo_reg[DV_ST][31:0];
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = out_reg;

endmodule
